// File: rtl/rgbapm_pkg.sv
// Shared types and constants for the RGBA8 alpha premultiply unit.
// No dependencies; every other file in rtl/ refers to it by scoped names.
package rgbapm_pkg;

  localparam int BYTE_W      = 8;
  localparam int NUM_BYTES   = 4;
  localparam int NUM_COLOURS = 3;
  // one division cell per quotient bit
  localparam int NUM_CELLS   = BYTE_W;
  localparam int PROD_W      = 2 * BYTE_W;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 1;

  // rounding term of the divide-by-255 shift-add form
  localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(128);
  localparam logic [BYTE_W-1:0] BYTE_MAX   = BYTE_W'(255);

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_UNPREMUL    = 1'b0,
    REG_ALPHA_FIRST = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic unpremul;
    logic alpha_first;
  } cfg_t;

  typedef struct packed {
    logic [BYTE_W-1:0] pixel_byte_0;
    logic [BYTE_W-1:0] pixel_byte_1;
    logic [BYTE_W-1:0] pixel_byte_2;
    logic [BYTE_W-1:0] pixel_byte_3;
    logic              span_end;
  } pix_in_t;

  typedef struct packed {
    logic [BYTE_W-1:0] result_byte_0;
    logic [BYTE_W-1:0] result_byte_1;
    logic [BYTE_W-1:0] result_byte_2;
    logic [BYTE_W-1:0] result_byte_3;
    logic              result_span_end;
  } pix_out_t;

  // One colour lane: partial remainder, dividend bits that shift out as
  // quotient bits shift in, and the saturation flag.
  typedef struct packed {
    logic [BYTE_W-1:0] rem;
    logic [BYTE_W-1:0] quo;
    logic              sat;
  } lane_t;

  typedef struct packed {
    cfg_t                                cfg;
    logic [BYTE_W-1:0]                   alpha;
    logic [NUM_BYTES-1:0][BYTE_W-1:0]    bytes;
    logic                                span_end;
    lane_t [NUM_COLOURS-1:0]             lanes;
  } work_t;

endpackage

// File: rtl/rgbapm_front.sv
// Front of the pipeline: input register, colour-by-alpha multiply stage and
// per-lane setup for the division cells. Depends on rgbapm_pkg.
module rgbapm_front (
  input  logic                clk,
  input  logic                rst_n,
  input  rgbapm_pkg::cfg_t    cfg,
  input  logic                in_valid,
  output logic                in_ready,
  input  rgbapm_pkg::pix_in_t in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output rgbapm_pkg::work_t   out_work
);

  logic                                a_valid_r;
  logic                                a_ready;
  rgbapm_pkg::work_t                   a_work_r;
  rgbapm_pkg::work_t                   a_work_nxt;
  logic [rgbapm_pkg::NUM_COLOURS-1:0][rgbapm_pkg::PROD_W-1:0] prod_nxt;

  logic                                b_valid_r;
  logic                                b_ready;
  rgbapm_pkg::work_t                   b_work_r;
  logic [rgbapm_pkg::NUM_COLOURS-1:0][rgbapm_pkg::PROD_W-1:0] b_prod_r;

  assign a_ready   = !a_valid_r || b_ready;
  assign b_ready   = !b_valid_r || out_ready;
  assign in_ready  = a_ready;
  assign out_valid = b_valid_r;

  // capture the pixel together with the mode it is to be converted in
  always_comb begin
    a_work_nxt          = '0;
    a_work_nxt.cfg      = cfg;
    a_work_nxt.bytes    = {in_item.pixel_byte_3, in_item.pixel_byte_2,
                           in_item.pixel_byte_1, in_item.pixel_byte_0};
    a_work_nxt.alpha    = cfg.alpha_first ? in_item.pixel_byte_0 : in_item.pixel_byte_3;
    a_work_nxt.span_end = in_item.span_end;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (a_ready) begin
      a_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && a_ready) begin
      a_work_r <= a_work_nxt;
    end
  end

  // colour lane k sits one byte up when alpha leads
  always_comb begin
    logic [1:0]                    idx;
    logic [rgbapm_pkg::BYTE_W-1:0] c;
    for (int k = 0; k < rgbapm_pkg::NUM_COLOURS; k++) begin
      idx         = 2'(k) + {1'b0, a_work_r.cfg.alpha_first};
      c           = a_work_r.bytes[idx];
      prod_nxt[k] = (c * a_work_r.alpha) + rgbapm_pkg::ROUND_HALF;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (b_ready) begin
      b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (a_valid_r && b_ready) begin
      b_work_r <= a_work_r;
      b_prod_r <= prod_nxt;
    end
  end

  // Premultiply finishes here with ((t >> 8) + t) >> 8; unpremultiply loads
  // the dividend c*255 = (c << 8) - c into remainder and shift bits.
  always_comb begin
    logic [1:0]                      idx;
    logic [rgbapm_pkg::BYTE_W-1:0]   c;
    logic [rgbapm_pkg::PROD_W:0]     sum;
    logic [rgbapm_pkg::PROD_W-1:0]   dvd;
    out_work = b_work_r;
    for (int k = 0; k < rgbapm_pkg::NUM_COLOURS; k++) begin
      idx = 2'(k) + {1'b0, b_work_r.cfg.alpha_first};
      c   = b_work_r.bytes[idx];
      sum = {1'b0, b_prod_r[k]}
            + {{(rgbapm_pkg::BYTE_W + 1){1'b0}},
               b_prod_r[k][rgbapm_pkg::PROD_W-1:rgbapm_pkg::BYTE_W]};
      dvd = {c, {rgbapm_pkg::BYTE_W{1'b0}}} - {{rgbapm_pkg::BYTE_W{1'b0}}, c};
      if (b_work_r.cfg.unpremul) begin
        out_work.lanes[k].rem = dvd[rgbapm_pkg::PROD_W-1:rgbapm_pkg::BYTE_W];
        out_work.lanes[k].quo = dvd[rgbapm_pkg::BYTE_W-1:0];
        out_work.lanes[k].sat = c > b_work_r.alpha;
      end else begin
        out_work.lanes[k].rem = '0;
        out_work.lanes[k].quo = sum[rgbapm_pkg::PROD_W-1:rgbapm_pkg::BYTE_W];
        out_work.lanes[k].sat = 1'b0;
      end
    end
  end

endmodule

// File: rtl/rgbapm_cell.sv
// One restoring-division cell: one quotient bit for each colour lane per
// item, held in its own pipeline register. Depends on rgbapm_pkg.
module rgbapm_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  rgbapm_pkg::work_t in_work,
  output logic              out_valid,
  input  logic              out_ready,
  output rgbapm_pkg::work_t out_work
);

  logic              valid_r;
  rgbapm_pkg::work_t work_r;
  rgbapm_pkg::work_t work_nxt;

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_work  = work_r;

  // shift the next dividend bit into the remainder, subtract alpha if it fits
  always_comb begin
    logic [rgbapm_pkg::BYTE_W:0] shifted;
    logic [rgbapm_pkg::BYTE_W:0] diff;
    logic                        qbit;
    work_nxt = in_work;
    for (int k = 0; k < rgbapm_pkg::NUM_COLOURS; k++) begin
      shifted = {in_work.lanes[k].rem, in_work.lanes[k].quo[rgbapm_pkg::BYTE_W-1]};
      diff    = shifted - {1'b0, in_work.alpha};
      qbit    = shifted >= {1'b0, in_work.alpha};
      if (in_work.cfg.unpremul) begin
        work_nxt.lanes[k].rem = qbit ? diff[rgbapm_pkg::BYTE_W-1:0]
                                     : shifted[rgbapm_pkg::BYTE_W-1:0];
        work_nxt.lanes[k].quo = {in_work.lanes[k].quo[rgbapm_pkg::BYTE_W-2:0], qbit};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      work_r <= work_nxt;
    end
  end

endmodule

// File: rtl/rgbapm_back.sv
// Output stage: saturate or zero the quotients, put the colours back around
// the alpha byte and hold the finished item. Depends on rgbapm_pkg.
module rgbapm_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  rgbapm_pkg::work_t    in_work,
  output logic                 out_valid,
  input  logic                 out_ready,
  output rgbapm_pkg::pix_out_t out_item
);

  logic                 valid_r;
  rgbapm_pkg::pix_out_t item_r;
  rgbapm_pkg::pix_out_t item_nxt;
  logic [rgbapm_pkg::NUM_COLOURS-1:0][rgbapm_pkg::BYTE_W-1:0] val;

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_item  = item_r;

  always_comb begin
    for (int k = 0; k < rgbapm_pkg::NUM_COLOURS; k++) begin
      if (!in_work.cfg.unpremul) begin
        val[k] = in_work.lanes[k].quo;
      end else if (in_work.alpha == '0) begin
        val[k] = '0;
      end else if (in_work.lanes[k].sat) begin
        val[k] = rgbapm_pkg::BYTE_MAX;
      end else begin
        val[k] = in_work.lanes[k].quo;
      end
    end
  end

  always_comb begin
    if (in_work.cfg.alpha_first) begin
      item_nxt.result_byte_0 = in_work.bytes[0];
      item_nxt.result_byte_1 = val[0];
      item_nxt.result_byte_2 = val[1];
      item_nxt.result_byte_3 = val[2];
    end else begin
      item_nxt.result_byte_0 = val[0];
      item_nxt.result_byte_1 = val[1];
      item_nxt.result_byte_2 = val[2];
      item_nxt.result_byte_3 = in_work.bytes[3];
    end
    item_nxt.result_span_end = in_work.span_end;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= item_nxt;
    end
  end

endmodule

// File: rtl/rgba8_alpha_premultiply_unit.sv
// Top level of the RGBA8 alpha premultiply / unpremultiply unit.
// Depends on rgbapm_pkg, rgbapm_front, rgbapm_cell and rgbapm_back.
//
// Usage:
//   in_*  : one four-byte pixel and a span marker per item (valid/ready).
//   out_* : the converted pixel, bytes in input order, alpha unchanged.
//   cfg_* : register writes, always ready; index 0 selects premultiply (0)
//           or unpremultiply (1), index 1 places alpha last (0) or first (1).
//           Write them only while no item is in flight.
// Pipeline: eleven register stages - input register, multiply stage, eight
//   division cells (one quotient bit each) and the output register.
// Throughput: one item per cycle while out_ready is high; every stage takes
//   a new item in the cycle its current one moves on, per the stage handshake.
// Reset: clears every stage valid and both registers to zero (premultiply,
//   alpha last). Payload registers are not reset.
// Stall: while out_ready is low the output item holds; items behind it keep
//   advancing into empty stages, and in_ready drops only once every stage
//   holds an item.
module rgba8_alpha_premultiply_unit (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  rgbapm_pkg::pix_in_t                     in_item,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output rgbapm_pkg::pix_out_t                    out_item,
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [rgbapm_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [rgbapm_pkg::CFG_DATA_W-1:0]       cfg_data
);

  rgbapm_pkg::cfg_t cfg_r;
  rgbapm_pkg::cfg_t cfg_nxt;

  logic                                     front_valid;
  logic                                     front_ready;
  rgbapm_pkg::work_t                        front_work;

  logic              [rgbapm_pkg::NUM_CELLS:0] chain_valid;
  logic              [rgbapm_pkg::NUM_CELLS:0] chain_ready;
  rgbapm_pkg::work_t [rgbapm_pkg::NUM_CELLS:0] chain_work;

  // configuration: always ready, decode the register index
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (rgbapm_pkg::cfg_reg_t'(cfg_index))
        rgbapm_pkg::REG_UNPREMUL:    cfg_nxt.unpremul    = cfg_data[0];
        rgbapm_pkg::REG_ALPHA_FIRST: cfg_nxt.alpha_first = cfg_data[0];
        default:                     cfg_nxt             = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // input register, multiply and divider setup
  rgbapm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (front_valid),
    .out_ready (front_ready),
    .out_work  (front_work)
  );

  assign chain_valid[0] = front_valid;
  assign chain_work[0]  = front_work;
  assign front_ready    = chain_ready[0];

  // row of division cells; premultiplied lanes ride through untouched
  for (genvar i = 0; i < rgbapm_pkg::NUM_CELLS; i++) begin : g_cell
    rgbapm_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (chain_valid[i]),
      .in_ready  (chain_ready[i]),
      .in_work   (chain_work[i]),
      .out_valid (chain_valid[i+1]),
      .out_ready (chain_ready[i+1]),
      .out_work  (chain_work[i+1])
    );
  end

  // saturation, byte placement and output register
  rgbapm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (chain_valid[rgbapm_pkg::NUM_CELLS]),
    .in_ready  (chain_ready[rgbapm_pkg::NUM_CELLS]),
    .in_work   (chain_work[rgbapm_pkg::NUM_CELLS]),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  // a stall on the input can only come from a full pipe behind a held output
  assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with no output item waiting");

  // unpremultiply, alpha first: zero alpha clears every colour
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && cfg_r.unpremul && cfg_r.alpha_first && out_item.result_byte_0 == '0
    |-> out_item.result_byte_1 == '0 && out_item.result_byte_2 == '0
        && out_item.result_byte_3 == '0)
    else $error("zero alpha left a colour set");

  // premultiply, alpha last: no colour may exceed its alpha
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !cfg_r.unpremul && !cfg_r.alpha_first
    |-> out_item.result_byte_0 <= out_item.result_byte_3
        && out_item.result_byte_1 <= out_item.result_byte_3
        && out_item.result_byte_2 <= out_item.result_byte_3)
    else $error("premultiplied colour above alpha");

endmodule
